/* rtl/assert_macros.svh */
// assertion macros used by the top level, the only rtl file that checks itself
// no dependencies; each macro takes a label, clock, active-low reset and expressions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* rtl/utj_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and character helpers for the utf-8 to json escape block
// no dependencies
package utj_pkg;

	localparam int JOB_DEPTH = 4;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_LENGTH = 2'd1;
	localparam logic [1:0] ERR_TRUNC  = 2'd2;

	localparam logic REG_USE_EXT = 1'b0;
	localparam logic REG_UPPER   = 1'b1;

	localparam logic [7:0] CH_BSL  = 8'h5c;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_U    = 8'h75;
	localparam logic [7:0] CH_X    = 8'h78;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_B    = 8'h62;
	localparam logic [7:0] CH_F    = 8'h66;
	localparam logic [7:0] CH_N    = 8'h6e;
	localparam logic [7:0] CH_R    = 8'h72;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_NUL  = 8'h00;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_of_run;
		logic [1:0] error;
	} out_t;

	typedef enum logic [2:0] {
		JK_RAW,
		JK_PAIR,
		JK_CTRL,
		JK_UNI,
		JK_ERR
	} job_kind_t;

	// data: raw byte, escape letter, control byte, code point or error code
	typedef struct packed {
		job_kind_t   kind;
		logic [15:0] data;
	} job_t;

	function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
		logic [7:0] base;
		base = upper ? 8'h41 : 8'h61;
		if (v < 4'd10) begin
			return CH_ZERO + {4'h0, v};
		end
		return base + {4'h0, v} - 8'd10;
	endfunction

	function automatic logic [2:0] job_len(input job_kind_t kind, input logic use_ext);
		logic [2:0] n;
		unique case (kind)
			JK_RAW, JK_ERR: n = 3'd1;
			JK_PAIR:        n = 3'd2;
			JK_CTRL:        n = use_ext ? 3'd4 : 3'd6;
			JK_UNI:         n = 3'd6;
			default:        n = 3'd1;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] job_char(input job_t job, input logic [2:0] idx,
	                                        input logic use_ext, input logic upper);
		logic [7:0] c;
		logic [3:0] nib;
		c = CH_NUL;
		nib = 4'h0;
		unique case (job.kind)
			JK_RAW: c = job.data[7:0];
			JK_ERR: c = CH_NUL;
			JK_PAIR: c = (idx == 3'd0) ? CH_BSL : job.data[7:0];
			JK_UNI: begin
				unique case (idx)
					3'd0:    c = CH_BSL;
					3'd1:    c = CH_U;
					3'd2:    nib = job.data[15:12];
					3'd3:    nib = job.data[11:8];
					3'd4:    nib = job.data[7:4];
					default: nib = job.data[3:0];
				endcase
				if (idx >= 3'd2) begin
					c = hex_char(nib, upper);
				end
			end
			JK_CTRL: begin
				if (use_ext) begin
					unique case (idx)
						3'd0:    c = CH_BSL;
						3'd1:    c = CH_X;
						3'd2:    c = hex_char(job.data[7:4], upper);
						default: c = hex_char(job.data[3:0], upper);
					endcase
				end else begin
					unique case (idx)
						3'd0:       c = CH_BSL;
						3'd1:       c = CH_U;
						3'd2, 3'd3: c = CH_ZERO;
						3'd4:       c = hex_char(job.data[7:4], upper);
						default:    c = hex_char(job.data[3:0], upper);
					endcase
				end
			end
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

/* rtl/utj_front.sv */
`timescale 1ns / 1ps
// front end: tracks utf-8 sequences, makes a job per complete character or error
// depends on utj_pkg
module utj_front (
	input  logic          clk,
	input  logic          arst_n,
	input  utj_pkg::in_t  item,
	input  logic          accept,
	output logic          job_valid,
	output utj_pkg::job_t job,
	output logic [1:0]    pending
);

	logic [1:0]  pend_q;
	logic [15:0] code_q;
	logic [1:0]  pend_d;
	logic [15:0] code_d;
	logic [7:0]  b;
	logic        eot;
	logic [1:0]  pend_dec;
	logic [15:0] code_shift;

	assign b          = item.in_byte;
	assign eot        = item.end_of_text;
	assign pend_dec   = pend_q - 2'd1;
	assign code_shift = {code_q[9:0], b[5:0]};
	assign pending    = pend_q;

	always_comb begin
		pend_d    = pend_q;
		code_d    = code_q;
		job_valid = 1'b0;
		job.kind  = utj_pkg::JK_RAW;
		job.data  = {8'h00, b};
		if (pend_q != 2'd0) begin
			if (pend_dec != 2'd0) begin
				if (eot) begin
					job_valid = 1'b1;
					job.kind  = utj_pkg::JK_ERR;
					job.data  = {14'h0, utj_pkg::ERR_TRUNC};
					pend_d    = 2'd0;
					code_d    = 16'h0;
				end else begin
					pend_d = pend_dec;
					code_d = code_shift;
				end
			end else begin
				job_valid = 1'b1;
				job.kind  = utj_pkg::JK_UNI;
				job.data  = code_shift;
				pend_d    = 2'd0;
				code_d    = 16'h0;
			end
		end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110) begin
			// lead byte of a two or three byte sequence
			if (eot) begin
				job_valid = 1'b1;
				job.kind  = utj_pkg::JK_ERR;
				job.data  = {14'h0, utj_pkg::ERR_TRUNC};
				pend_d    = 2'd0;
				code_d    = 16'h0;
			end else if (b[5] == 1'b0) begin
				pend_d = 2'd1;
				code_d = {11'h0, b[4:0]};
			end else begin
				pend_d = 2'd2;
				code_d = {12'h0, b[3:0]};
			end
		end else if (b >= 8'hf0 && b <= 8'hfd) begin
			job_valid = 1'b1;
			job.kind  = utj_pkg::JK_ERR;
			job.data  = {14'h0, utj_pkg::ERR_LENGTH};
			pend_d    = 2'd0;
			code_d    = 16'h0;
		end else begin
			job_valid = 1'b1;
			unique case (b)
				utj_pkg::CH_QUOT, utj_pkg::CH_BSL: job.kind = utj_pkg::JK_PAIR;
				8'h08: begin
					job.kind = utj_pkg::JK_PAIR;
					job.data = {8'h00, utj_pkg::CH_B};
				end
				8'h0c: begin
					job.kind = utj_pkg::JK_PAIR;
					job.data = {8'h00, utj_pkg::CH_F};
				end
				8'h0a: begin
					job.kind = utj_pkg::JK_PAIR;
					job.data = {8'h00, utj_pkg::CH_N};
				end
				8'h0d: begin
					job.kind = utj_pkg::JK_PAIR;
					job.data = {8'h00, utj_pkg::CH_R};
				end
				8'h09: begin
					job.kind = utj_pkg::JK_PAIR;
					job.data = {8'h00, utj_pkg::CH_T};
				end
				default: begin
					job.kind = (b < 8'h20) ? utj_pkg::JK_CTRL : utj_pkg::JK_RAW;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			code_q <= 16'h0;
		end else if (accept) begin
			pend_q <= pend_d;
			code_q <= code_d;
		end
	end

endmodule

/* rtl/utj_job_fifo.sv */
`timescale 1ns / 1ps
// small register queue of jobs between the front and back ends
// depends on utj_pkg
module utj_job_fifo #(
	parameter int DEPTH = utj_pkg::JOB_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  utj_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output utj_pkg::job_t rd_data,
	output logic          rd_valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	utj_pkg::job_t slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full     = count_q == FULL_CNT;
	assign rd_valid = count_q != '0;
	assign rd_data  = slots_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/utj_back.sv */
`timescale 1ns / 1ps
// back end: expands a job into characters, one beat per cycle while out_q has room
// depends on utj_pkg
module utj_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          use_ext,
	input  logic          upper,
	input  logic          job_valid,
	input  utj_pkg::job_t job,
	output logic          job_pop,
	output utj_pkg::out_t result,
	output logic          empty,
	input  logic          pop
);

	utj_pkg::job_t job_q;
	logic [2:0]    idx_q;
	logic          busy_q;
	utj_pkg::out_t out_q;
	logic          out_valid_q;
	logic          room;
	logic          emit;
	logic          last;
	logic [2:0]    len;

	assign len     = utj_pkg::job_len(job_q.kind, use_ext);
	assign last    = idx_q == len - 3'd1;
	assign room    = !out_valid_q || pop;
	assign emit    = room && busy_q;
	assign job_pop = job_valid && (!busy_q || (emit && last));
	assign result  = out_q;
	assign empty   = !out_valid_q;

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (emit) begin
			out_q.out_char    <= utj_pkg::job_char(job_q, idx_q, use_ext, upper);
			out_q.last_of_run <= last;
			out_q.error       <= (job_q.kind == utj_pkg::JK_ERR) ? job_q.data[1:0]
			                                                     : utj_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 3'd0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				idx_q  <= 3'd0;
				busy_q <= 1'b1;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/utf8_to_json_escape_stream.sv */
`timescale 1ns / 1ps
// top level: utf-8 bytes in, json-escaped ascii characters out
// depends on utj_pkg, utj_front, utj_job_fifo, utj_back, assert_macros.svh
//
//   channel   handshake          beat
//   input     push / full        item   (in_byte, end_of_text)
//   result    pop / empty        result (out_char, last_of_run, error)
//   config    cfg_we             cfg_idx, cfg_data
//
// a pushed byte is taken while the job queue has room and yields 0 to 6 characters
// the back end sends one character per cycle unless an unpopped result stalls it
// each job goes from a queue slot through the job register to the output register
// reset clears sequence state, queue and output register; no clearing pass
module utf8_to_json_escape_stream #(
	parameter int JOB_DEPTH = utj_pkg::JOB_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  utj_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output utj_pkg::out_t result,
	input  logic          cfg_we,
	input  logic          cfg_idx,
	input  logic          cfg_data
);

	`include "assert_macros.svh"

	logic          use_ext_q;
	logic          upper_q;
	logic          accept;
	logic          front_valid;
	utj_pkg::job_t front_job;
	logic [1:0]    pending;
	utj_pkg::job_t q_job;
	logic          q_valid;
	logic          q_pop;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_ext_q <= 1'b0;
			upper_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				utj_pkg::REG_USE_EXT: use_ext_q <= cfg_data;
				utj_pkg::REG_UPPER:   upper_q   <= cfg_data;
				default:              use_ext_q <= use_ext_q;
			endcase
		end
	end

	utj_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.accept    (accept),
		.job_valid (front_valid),
		.job       (front_job),
		.pending   (pending)
	);

	utj_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept && front_valid),
		.wr_data  (front_job),
		.full     (full),
		.rd_en    (q_pop),
		.rd_data  (q_job),
		.rd_valid (q_valid)
	);

	utj_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.use_ext   (use_ext_q),
		.upper     (upper_q),
		.job_valid (q_valid),
		.job       (q_job),
		.job_pop   (q_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	// an error beat stands alone and carries no character
	`ASSERT_IMPLY(a_err_beat, clk, arst_n,
		!empty && result.error != utj_pkg::ERR_NONE,
		result.last_of_run && result.out_char == utj_pkg::CH_NUL)
	// end of text always leaves no sequence open
	`ASSERT_NEXT(a_eot_clears, clk, arst_n, accept && item.end_of_text, pending == 2'd0)
	`ASSERT_IMPLY(a_pend_range, clk, arst_n, 1'b1, pending != 2'd3)

endmodule
